// ===== hw/rtl/assert_macros.svh =====
// assertion macros used by the rtl core
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while in reset
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while in reset
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/hcbp_pkg.sv =====
// types, constants and helpers of the huffman code bit packer
package hcbp_pkg;

    // field widths
    localparam int MODE_W = 2;
    localparam int SYM_W  = 8;
    localparam int WORD_W = 32;
    localparam int LEN_W  = 6;
    localparam int BYTE_W = 8;

    // packing buffer: residue bits plus one whole code word
    localparam int BUF_W = WORD_W + BYTE_W;
    localparam int CNT_W = $clog2(BUF_W + 1);

    // parameter defaults
    localparam int MAX_CODE_LEN_DEF = 32;
    localparam int NUM_SYMBOLS_DEF  = 256;

    // depth of the queue between front and back, power of two
    localparam int QUEUE_DEPTH = 2;

    typedef enum logic [MODE_W-1:0] {
        MODE_LOAD   = 2'd0,
        MODE_ENCODE = 2'd1,
        MODE_FLUSH  = 2'd2
    } t_mode;

    // one code table entry, code left aligned in the word
    typedef struct packed {
        logic [WORD_W-1:0] code;
        logic [LEN_W-1:0]  len;
    } t_entry;

    // one operation passed from front to back
    typedef struct packed {
        logic              flush;
        logic [WORD_W-1:0] code;
        logic [LEN_W-1:0]  len;
    } t_op;

    // queue status seen by both sides
    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

    // move a right-aligned code of len bits to the top of the word, zeros below
    function automatic logic [WORD_W-1:0] align_code(input logic [WORD_W-1:0] word,
                                                     input logic [LEN_W-1:0]  len);
        logic [LEN_W:0] sh;
        sh = (LEN_W + 1)'(WORD_W) - {1'b0, len};
        return word << sh;
    endfunction

endpackage

// ===== hw/rtl/hcbp_if.sv =====
// request channel interfaces of the huffman code bit packer
interface hcbp_in_if
    import hcbp_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [MODE_W-1:0] mode;
    logic [SYM_W-1:0]  symbol;
    logic [WORD_W-1:0] code_word;
    logic [LEN_W-1:0]  code_length;

    modport source (output valid, mode, symbol, code_word, code_length, input ready);
    modport sink   (input valid, mode, symbol, code_word, code_length, output ready);
endinterface

interface hcbp_out_if
    import hcbp_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] out_byte;
    logic              last;

    modport source (output valid, out_byte, last, input ready);
    modport sink   (input valid, out_byte, last, output ready);
endinterface

// ===== hw/rtl/huffman_code_bit_packer_core.sv =====
// huffman code bit packer: code table lookup in front, msb-first byte packer behind
// a request is taken each cycle while the two-entry queue has room or the lookup stage is empty
// an encode that yields k bytes holds the packer until they are drained, one byte a cycle while the output slot is free
// a first byte passes the lookup stage, the queue, the packing registers and the output register in turn
// synchronous active-low reset empties the pipeline and the packer; the table is not cleared
`include "assert_macros.svh"

module huffman_code_bit_packer_core
    import hcbp_pkg::*;
#(
    parameter int MAX_CODE_LEN = MAX_CODE_LEN_DEF,
    parameter int NUM_SYMBOLS  = NUM_SYMBOLS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    hcbp_in_if.sink    i_in,
    hcbp_out_if.source o_out
);

    localparam logic [CNT_W-1:0] MaxBits  = CNT_W'(BUF_W - 1);
    localparam logic [CNT_W-1:0] PadCount = CNT_W'(BYTE_W);

    logic             q_push;
    logic             q_pop;
    t_op              q_push_op;
    t_op              q_pop_op;
    t_q_status        q_status;
    logic [CNT_W-1:0] bit_count;

    // lookup front end
    hcbp_front #(
        .MAX_CODE_LEN (MAX_CODE_LEN),
        .NUM_SYMBOLS  (NUM_SYMBOLS)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (i_in),
        .i_q_status (q_status),
        .o_push     (q_push),
        .o_push_op  (q_push_op)
    );

    // decoupling queue
    hcbp_queue u_queue (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_push    (q_push),
        .i_push_op (q_push_op),
        .i_pop     (q_pop),
        .o_pop_op  (q_pop_op),
        .o_status  (q_status)
    );

    // bit packer
    hcbp_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_status  (q_status),
        .i_pop_op    (q_pop_op),
        .o_pop       (q_pop),
        .o_out       (o_out),
        .o_bit_count (bit_count)
    );

    // checks
    `ASSERT_IMPLIES(a_push_not_full, i_clk, i_rst_n, q_push, !q_status.full, "push into full queue")
    `ASSERT_IMPLIES(a_pop_not_empty, i_clk, i_rst_n, q_pop, !q_status.empty, "pop from empty queue")
    `ASSERT_IMPLIES(a_bits_in_range, i_clk, i_rst_n, 1'b1, bit_count <= MaxBits, "packer overflow")
    `ASSERT_NEXT(a_flush_pads, i_clk, i_rst_n, q_pop && q_pop_op.flush && (bit_count != '0), bit_count == PadCount, "flush did not pad to a byte")

endmodule

// ===== hw/rtl/hcbp_front.sv =====
// front: accepts requests, keeps the code table and looks up encode symbols
module hcbp_front
    import hcbp_pkg::*;
#(
    parameter int MAX_CODE_LEN = MAX_CODE_LEN_DEF,
    parameter int NUM_SYMBOLS  = NUM_SYMBOLS_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    hcbp_in_if.sink   i_in,
    input  t_q_status i_q_status,
    output logic      o_push,
    output t_op       o_push_op
);

    localparam int SymAw = (NUM_SYMBOLS > 1) ? $clog2(NUM_SYMBOLS) : 1;
    localparam int LenLimit = (MAX_CODE_LEN < WORD_W) ? MAX_CODE_LEN : WORD_W;
    localparam logic [LEN_W-1:0] MaxLen = LEN_W'(LenLimit);

    t_entry             r_table [NUM_SYMBOLS];
    t_entry             r_rd;
    logic               r_s1_valid;
    logic               r_s1_flush;
    logic               accept;
    logic               sym_ok;
    logic               is_load;
    logic               is_enc;
    logic               is_flush;
    logic [SymAw-1:0]   idx;

    // request classification
    always_comb begin
        is_load  = 1'b0;
        is_enc   = 1'b0;
        is_flush = 1'b0;
        unique case (t_mode'(i_in.mode))
            MODE_LOAD:   is_load  = 1'b1;
            MODE_ENCODE: is_enc   = 1'b1;
            MODE_FLUSH:  is_flush = 1'b1;
            default: ;
        endcase
    end

    assign sym_ok = {1'b0, i_in.symbol} < (SYM_W + 1)'(NUM_SYMBOLS);
    assign idx    = i_in.symbol[SymAw-1:0];

    // stage one may refill while it hands its operation on
    assign o_push     = r_s1_valid && !i_q_status.full;
    assign i_in.ready = !r_s1_valid || !i_q_status.full;
    assign accept     = i_in.valid && i_in.ready;

    // code table write, overlong codes are dropped
    always_ff @(posedge i_clk) begin
        if (accept && is_load && sym_ok && (i_in.code_length <= MaxLen)) begin
            r_table[idx] <= '{code: align_code(i_in.code_word, i_in.code_length),
                              len:  i_in.code_length};
        end
    end

    // registered table read
    always_ff @(posedge i_clk) begin
        if (accept && is_enc && sym_ok) begin
            r_rd <= r_table[idx];
        end
    end

    // lookup stage holding register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (accept && ((is_enc && sym_ok) || is_flush)) begin
            r_s1_valid <= 1'b1;
        end else if (o_push) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_flush <= is_flush;
        end
    end

    assign o_push_op = '{flush: r_s1_flush, code: r_rd.code, len: r_rd.len};

endmodule

// ===== hw/rtl/hcbp_queue.sv =====
// short fifo of operations between front and back
module hcbp_queue
    import hcbp_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_push,
    input  t_op       i_push_op,
    input  logic      i_pop,
    output t_op       o_pop_op,
    output t_q_status o_status
);

    localparam int QAw = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

    t_op            r_mem [QUEUE_DEPTH];
    logic [QAw-1:0] r_wp;
    logic [QAw-1:0] r_rp;
    logic [QAw:0]   r_count;

    // storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_push_op;
        end
    end

    // pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_rp    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    assign o_pop_op       = r_mem[r_rp];
    assign o_status.full  = r_count == (QAw + 1)'(QUEUE_DEPTH);
    assign o_status.empty = r_count == '0;

endmodule

// ===== hw/rtl/hcbp_back.sv =====
// back: packs code bits msb first and drains whole bytes to the output register
module hcbp_back
    import hcbp_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_q_status        i_q_status,
    input  t_op              i_pop_op,
    output logic             o_pop,
    hcbp_out_if.source       o_out,
    output logic [CNT_W-1:0] o_bit_count
);

    localparam logic [CNT_W-1:0] ByteCnt    = CNT_W'(BYTE_W);
    localparam logic [CNT_W-1:0] TwoByteCnt = CNT_W'(2 * BYTE_W);

    // bits are kept left aligned, everything below the held bits is zero
    logic [BUF_W-1:0]  r_buf;
    logic [CNT_W-1:0]  r_cnt;
    logic [BUF_W-1:0]  n_buf;
    logic [CNT_W-1:0]  n_cnt;
    logic              r_ov;
    logic [BYTE_W-1:0] r_obyte;
    logic              r_olast;
    logic              emitting;
    logic              slot_free;
    logic              emit;

    assign emitting  = r_cnt >= ByteCnt;
    assign slot_free = !r_ov || o_out.ready;
    assign o_pop     = !emitting && !i_q_status.empty;

    // next packing state
    always_comb begin
        n_buf = r_buf;
        n_cnt = r_cnt;
        emit  = 1'b0;
        if (emitting) begin
            if (slot_free) begin
                emit  = 1'b1;
                n_buf = r_buf << BYTE_W;
                n_cnt = r_cnt - ByteCnt;
            end
        end else if (o_pop) begin
            if (i_pop_op.flush) begin
                // pad the partial byte with the zeros already below it
                if (r_cnt != '0) begin
                    n_cnt = ByteCnt;
                end
            end else begin
                n_buf = r_buf | ({i_pop_op.code, {BYTE_W{1'b0}}} >> r_cnt);
                n_cnt = r_cnt + CNT_W'(i_pop_op.len);
            end
        end
    end

    // packing registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_buf <= '0;
            r_cnt <= '0;
        end else begin
            r_buf <= n_buf;
            r_cnt <= n_cnt;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (emit) begin
            r_ov <= 1'b1;
        end else if (o_out.ready) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_obyte <= r_buf[BUF_W-1 -: BYTE_W];
            r_olast <= r_cnt < TwoByteCnt;
        end
    end

    assign o_out.valid    = r_ov;
    assign o_out.out_byte = r_obyte;
    assign o_out.last     = r_olast;
    assign o_bit_count    = r_cnt;

endmodule

// ===== sim/hcbp_checker.sv =====
`timescale 1ns / 1ps
// checker of the code bit packer: predicts the packed bytes and compares them
module hcbp_checker
    import hcbp_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    hcbp_in_if   i_in,
    hcbp_out_if  i_out,
    output int   o_errors,
    output int   o_outstanding,
    output int   o_bytes_seen
);

    typedef struct {
        logic [BYTE_W-1:0] value;
        logic              last;
    } t_packed_byte;

    // mirror of the code table and of the partial byte
    logic [WORD_W-1:0] table_code [NUM_SYMBOLS_DEF];
    logic [LEN_W-1:0]  table_len  [NUM_SYMBOLS_DEF];
    logic [6:0]        pend_bits  = '0;
    logic [2:0]        pend_count = '0;

    t_packed_byte expected_bytes [$];
    int errors     = 0;
    int bytes_seen = 0;

    // work out the bytes one accepted request gives and queue them
    function automatic void pack_request(input logic [MODE_W-1:0] mode,
                                         input logic [SYM_W-1:0]  sym,
                                         input logic [WORD_W-1:0] word,
                                         input logic [LEN_W-1:0]  len);
        t_packed_byte      made [$];
        logic [BYTE_W-1:0] grown;
        int                bit_pos;
        case (mode)
            MODE_LOAD: begin
                // overlong codes leave the entry as it was
                if (len <= MAX_CODE_LEN_DEF && len <= WORD_W) begin
                    table_code[sym] = word;
                    table_len[sym]  = len;
                end
            end
            MODE_ENCODE: begin
                // shift the code in msb first, a byte leaves whenever eight bits are held
                for (bit_pos = int'(table_len[sym]) - 1; bit_pos >= 0; bit_pos--) begin
                    grown = {pend_bits, table_code[sym][bit_pos]};
                    if (pend_count == 3'd7) begin
                        made.push_back('{grown, 1'b0});
                        pend_bits  = '0;
                        pend_count = '0;
                    end else begin
                        pend_bits  = grown[6:0];
                        pend_count = pend_count + 3'd1;
                    end
                end
            end
            MODE_FLUSH: begin
                // pad with zeros at the low end, nothing when empty
                if (pend_count != 3'd0) begin
                    grown = {1'b0, pend_bits} << (BYTE_W - int'(pend_count));
                    made.push_back('{grown, 1'b0});
                    pend_bits  = '0;
                    pend_count = '0;
                end
            end
            default: ;
        endcase
        if (made.size() > 0)
            made[made.size()-1].last = 1'b1;
        foreach (made[k])
            expected_bytes.push_back(made[k]);
    endfunction

    // predict on accepted requests, compare on accepted bytes
    always @(posedge i_clk) begin : compare_bytes
        t_packed_byte want;
        if (i_rst_n) begin
            if (i_in.valid && i_in.ready)
                pack_request(i_in.mode, i_in.symbol, i_in.code_word, i_in.code_length);
            if (i_out.valid && i_out.ready) begin
                bytes_seen++;
                if (expected_bytes.size() == 0) begin
                    $error("out_byte: expected none, got %02h (last %0b)",
                           i_out.out_byte, i_out.last);
                    errors++;
                end else begin
                    want = expected_bytes.pop_front();
                    if (i_out.out_byte !== want.value) begin
                        $error("out_byte: expected %02h, got %02h", want.value, i_out.out_byte);
                        errors++;
                    end
                    if (i_out.last !== want.last) begin
                        $error("last: expected %0b, got %0b", want.last, i_out.last);
                        errors++;
                    end
                end
            end
        end
        o_errors      <= errors;
        o_outstanding <= expected_bytes.size();
        o_bytes_seen  <= bytes_seen;
    end

endmodule

// ===== sim/testbench.sv =====
`timescale 1ns / 1ps
// top of the code bit packer testbench: clock, reset, requests and verdict
module testbench;
    import hcbp_pkg::*;

    localparam logic [MODE_W-1:0] MODE_SPARE = 2'd3;
    localparam int CYCLE_LIMIT  = 300000;
    localparam int DRAIN_CYCLES = 20;
    localparam int RANDOM_ITEMS = 250;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;
    logic calm  = 1'b0;
    int   cycles = 0;
    int   errors, outstanding, bytes_seen;
    int   n_load = 0, n_encode = 0, n_flush = 0, n_spare = 0;

    // entries written so far, only these are ever encoded
    bit               loaded [NUM_SYMBOLS_DEF];
    logic [SYM_W-1:0] loaded_syms [$];

    hcbp_in_if  in_ch ();
    hcbp_out_if out_ch ();

    huffman_code_bit_packer_core DUT (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (in_ch.sink),
        .o_out   (out_ch.source)
    );

    hcbp_checker byte_check (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_in          (in_ch),
        .i_out         (out_ch),
        .o_errors      (errors),
        .o_outstanding (outstanding),
        .o_bytes_seen  (bytes_seen)
    );

    always #5 clk = ~clk;

    // back-pressure on the byte side
    always @(posedge clk) begin
        out_ch.ready <= calm || ($urandom_range(99) >= 10);
    end

    // hard stop on a hung run
    always @(posedge clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("testbench: errors");
            $finish;
        end
    end

    // mostly short codes, now and then long ones
    function automatic logic [LEN_W-1:0] rand_len();
        int roll;
        roll = $urandom_range(99);
        if (roll < 5)
            return '0;
        else if (roll < 70)
            return LEN_W'($urandom_range(9, 1));
        else if (roll < 92)
            return LEN_W'($urandom_range(24, 10));
        else
            return LEN_W'($urandom_range(32, 25));
    endfunction

    // hand one request over, with an occasional gap in front of it
    task automatic send_req(input logic [MODE_W-1:0] mode, input logic [SYM_W-1:0] sym,
                            input logic [WORD_W-1:0] word, input logic [LEN_W-1:0] len);
        if (!calm && $urandom_range(99) < 10) begin
            in_ch.valid <= 1'b0;
            @(posedge clk);
        end
        in_ch.valid       <= 1'b1;
        in_ch.mode        <= mode;
        in_ch.symbol      <= sym;
        in_ch.code_word   <= word;
        in_ch.code_length <= len;
        @(posedge clk);
        while (!in_ch.ready) @(posedge clk);
        case (mode)
            MODE_LOAD:   n_load++;
            MODE_ENCODE: n_encode++;
            MODE_FLUSH:  n_flush++;
            default:     n_spare++;
        endcase
        if (mode == MODE_LOAD && len <= MAX_CODE_LEN_DEF && !loaded[sym]) begin
            loaded[sym] = 1'b1;
            loaded_syms.push_back(sym);
        end
    endtask

    initial begin
        int roll;
        in_ch.valid       = 1'b0;
        in_ch.mode        = MODE_LOAD;
        in_ch.symbol      = '0;
        in_ch.code_word   = '0;
        in_ch.code_length = '0;
        out_ch.ready      = 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // directed: empty flush, zero and full lengths, overlong loads, unused mode
        send_req(MODE_FLUSH,  8'd0,   32'h0000_0000, 6'd0);
        send_req(MODE_LOAD,   8'd0,   32'hFFFF_FFFF, 6'd0);
        send_req(MODE_LOAD,   8'd255, 32'hFFFF_FFFF, 6'd32);
        send_req(MODE_LOAD,   8'd1,   32'h0000_0001, 6'd1);
        send_req(MODE_LOAD,   8'd2,   32'h0000_00A5, 6'd8);
        send_req(MODE_LOAD,   8'd3,   32'h8000_0000, 6'd32);
        send_req(MODE_LOAD,   8'd4,   32'hDEAD_0002, 6'd2);
        send_req(MODE_LOAD,   8'd5,   32'h0000_0055, 6'd7);
        send_req(MODE_LOAD,   8'd1,   32'h0000_0000, 6'd33);
        send_req(MODE_LOAD,   8'd2,   32'hFFFF_FFFF, 6'd63);
        send_req(MODE_ENCODE, 8'd0,   32'h0000_0000, 6'd0);
        send_req(MODE_ENCODE, 8'd1,   32'h0000_0000, 6'd0);
        send_req(MODE_FLUSH,  8'd0,   32'h0000_0000, 6'd0);
        send_req(MODE_ENCODE, 8'd255, 32'h0000_0000, 6'd0);
        send_req(MODE_ENCODE, 8'd1,   32'h0000_0000, 6'd0);
        send_req(MODE_ENCODE, 8'd255, 32'h0000_0000, 6'd0);
        send_req(MODE_ENCODE, 8'd2,   32'h0000_0000, 6'd0);
        send_req(MODE_SPARE,  8'hFF,  32'hFFFF_FFFF, 6'h3F);
        send_req(MODE_ENCODE, 8'd3,   32'h0000_0000, 6'd0);
        send_req(MODE_ENCODE, 8'd4,   32'h0000_0000, 6'd0);
        send_req(MODE_FLUSH,  8'd0,   32'h0000_0000, 6'd0);
        send_req(MODE_ENCODE, 8'd5,   32'h0000_0000, 6'd0);
        send_req(MODE_ENCODE, 8'd3,   32'h0000_0000, 6'd0);
        send_req(MODE_FLUSH,  8'd0,   32'h0000_0000, 6'd0);
        send_req(MODE_FLUSH,  8'hFF,  32'hFFFF_FFFF, 6'h3F);

        // random: table first, then mostly encodes with loads, flushes, unused mode
        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            calm <= (i >= 120 && i < 190);
            roll = $urandom_range(99);
            if (i < 30 || roll < 12)
                send_req(MODE_LOAD, SYM_W'($urandom_range(255)), $urandom, rand_len());
            else if (roll < 75)
                send_req(MODE_ENCODE, loaded_syms[$urandom_range(loaded_syms.size() - 1)],
                         $urandom, LEN_W'($urandom_range(63)));
            else if (roll < 88)
                send_req(MODE_FLUSH, SYM_W'($urandom_range(255)), $urandom,
                         LEN_W'($urandom_range(63)));
            else if (roll < 93)
                send_req(MODE_SPARE, SYM_W'($urandom_range(255)), $urandom,
                         LEN_W'($urandom_range(63)));
            else
                send_req(MODE_LOAD, SYM_W'($urandom_range(255)), $urandom,
                         LEN_W'($urandom_range(63, 33)));
        end
        in_ch.valid <= 1'b0;
        calm        <= 1'b0;

        // let the packer drain
        @(posedge clk);
        while (outstanding != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("summary: %0d loads, %0d encodes, %0d flushes, %0d unused-mode requests",
                 n_load, n_encode, n_flush, n_spare);
        $display("summary: %0d packed bytes compared, with and without stalls", bytes_seen);
        if (errors == 0)
            $display("testbench: clean");
        else
            $display("testbench: errors");
        $finish;
    end

endmodule
